[sv/glts_pkg.sv]
// ----------------------------------------------------------------------------
// glts_pkg : shared types and constants of the timestamp synchroniser
// Item structures, status codes, register indexes and derived widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glts_pkg;

  localparam int MAX_SENSORS       = 5;
  localparam int FRAMES_PER_SENSOR = 4096;
  localparam int TIME_BITS         = 48;

  localparam int SEN_W  = $clog2(MAX_SENSORS);
  localparam int IDX_W  = $clog2(FRAMES_PER_SENSOR);
  localparam int CNT_W  = $clog2(FRAMES_PER_SENSOR + 1);
  localparam int MEM_DEPTH = MAX_SENSORS * FRAMES_PER_SENSOR;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam int LIMIT_W = 34;
  localparam int CFG_W   = 34;

  // Result status codes.
  localparam logic [2:0] ST_PAIR     = 3'd0;
  localparam logic [2:0] ST_FIRST    = 3'd1;
  localparam logic [2:0] ST_BAD_QUAL = 3'd2;
  localparam logic [2:0] ST_THROTTLE = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_THROTTLE  = 2'd2;
  localparam logic [1:0] CFG_ENABLE    = 2'd3;

  typedef struct packed {
    logic                 mode;
    logic [2:0]           sensor_id;
    logic [TIME_BITS-1:0] event_time;
    logic [15:0]          std_east;
    logic [15:0]          std_north;
    logic [15:0]          std_up;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [2:0]           out_sensor;
    logic [11:0]          frame_index;
    logic [TIME_BITS-1:0] held_time;
    logic [TIME_BITS-1:0] next_time;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic                 a_lt_b;
    logic                 b_lt_a;
    logic [TIME_BITS-1:0] diff;
  } cmp_res_t;

endpackage

`default_nettype wire

[sv/glts_frame_mem.sv]
// ----------------------------------------------------------------------------
// glts_frame_mem : frame timestamp store
// One write port and one registered read port over all sensor tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glts_frame_mem (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [glts_pkg::ADDR_W-1:0]    wr_addr,
  input  wire logic [glts_pkg::TIME_BITS-1:0] wr_data,
  input  wire logic                          rd_en,
  input  wire logic [glts_pkg::ADDR_W-1:0]    rd_addr,
  output logic      [glts_pkg::TIME_BITS-1:0] rd_data
);

  logic [glts_pkg::TIME_BITS-1:0] mem [glts_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/glts_absdiff.sv]
// ----------------------------------------------------------------------------
// glts_absdiff : shared time compare unit
// Orders two timestamps and gives their absolute difference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glts_absdiff (
  input  wire logic [glts_pkg::TIME_BITS-1:0] a,
  input  wire logic [glts_pkg::TIME_BITS-1:0] b,
  output glts_pkg::cmp_res_t                 res
);

  logic [glts_pkg::TIME_BITS:0] d;

  always_comb begin
    d          = {1'b0, a} - {1'b0, b};
    res.a_lt_b = d[glts_pkg::TIME_BITS];
    res.diff   = res.a_lt_b ? (b - a) : d[glts_pkg::TIME_BITS-1:0];
    res.b_lt_a = !res.a_lt_b && (d[glts_pkg::TIME_BITS-1:0] != '0);
  end

endmodule

`default_nettype wire

[sv/gnss_lidar_timestamp_sync.sv]
// ----------------------------------------------------------------------------
// gnss_lidar_timestamp_sync : nearest-timestamp multi-sensor synchroniser
// Loads sorted frame timestamps per sensor and pairs GNSS records with the
// nearest frame of every enabled sensor.
// ----------------------------------------------------------------------------
// Channel   Ports                         Transaction taken when
// input     start, busy, in_item          start high and busy low at clk edge
// result    out_valid, out_item           out_valid high for one cycle
// config    cfg_we, cfg_index, cfg_wdata  cfg_we high at clk edge
//
// A frame load passes through S_DISP and S_LOAD. A GNSS record passes the
// quality and throttle checks, then per enabled sensor a binary search whose
// probes each read the frame memory and compare, the neighbour reads and the
// window check, and finally result emission per sensor. With full tables each
// search needs up to 13 probes. Every probe passes through the single read port
// of the frame memory and the one compare unit.
// Reset is synchronous and active low; it empties all tables by clearing the
// frame counts. Results cannot be held off by the receiver, and busy stays
// high until the last result of a transaction has been issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnss_lidar_timestamp_sync (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire glts_pkg::in_item_t        in_item,
  output logic                           out_valid,
  output glts_pkg::out_item_t            out_item,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [glts_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int NS = glts_pkg::MAX_SENSORS;
  localparam int TB = glts_pkg::TIME_BITS;
  localparam int SW = glts_pkg::SEN_W;
  localparam int IW = glts_pkg::IDX_W;
  localparam int CW = glts_pkg::CNT_W;
  localparam int AW = glts_pkg::ADDR_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_LOAD, S_SQ, S_QCHK, S_THR, S_SINIT, S_BS_RD, S_BS_CMP,
    S_NEAR, S_ONE, S_PREV, S_CUR, S_WIN, S_NEXT, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  glts_pkg::in_item_t  item_r, item_nxt;

  // Configuration registers.
  logic [glts_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [31:0]                  window_r, window_nxt;
  logic [31:0]                  thr_r, thr_nxt;
  logic [NS-1:0]                en_r, en_nxt;

  // Per-sensor state.
  logic [CW-1:0] count_r [NS];
  logic [CW-1:0] count_nxt [NS];
  logic [TB-1:0] newest_r [NS];
  logic [TB-1:0] newest_nxt [NS];
  logic [IW-1:0] sstart_r [NS];
  logic [IW-1:0] sstart_nxt [NS];
  logic [IW-1:0] found_r [NS];
  logic [IW-1:0] found_nxt [NS];
  logic [IW-1:0] held_idx_r [NS];
  logic [IW-1:0] held_idx_nxt [NS];

  logic          held_valid_r, held_valid_nxt;
  logic [TB-1:0] held_time_r, held_time_nxt;
  logic [TB-1:0] last_acc_r, last_acc_nxt;

  // Working registers of the sequencer.
  logic [glts_pkg::LIMIT_W-1:0] sq_r, sq_nxt;
  logic [1:0]                   qcnt_r, qcnt_nxt;
  logic [SW-1:0]                sen_r, sen_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [CW-1:0]                mid_r, mid_nxt;
  logic [TB-1:0]                gap_r, gap_nxt;
  logic [IW-1:0]                pick_r, pick_nxt;

  logic                out_valid_r, out_valid_nxt;
  glts_pkg::out_item_t out_r, out_nxt;

  // Memory and compare unit hookup.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [TB-1:0] mem_rdata;
  logic [TB-1:0] cmp_b;
  glts_pkg::cmp_res_t cmp;

  logic [CW-1:0] cnt_cur, mid_cur;
  logic [15:0]   sq_op;
  logic [31:0]   sq_prod;
  logic          last_flag;
  logic [TB-1:0] t;

  glts_frame_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (item_r.event_time),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  glts_absdiff u_cmp (
    .a   (t),
    .b   (cmp_b),
    .res (cmp)
  );

  function automatic logic [AW-1:0] mem_addr(logic [SW-1:0] s, logic [IW-1:0] i);
    return AW'(s) * AW'(glts_pkg::FRAMES_PER_SENSOR) + AW'(i);
  endfunction

  assign t         = item_r.event_time;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cnt_cur   = count_r[sen_r];
  assign mid_cur   = lo_r + ((hi_r - lo_r) >> 1);
  assign cmp_b     = (state_r == S_THR) ? last_acc_r : mem_rdata;

  always_comb begin
    case (qcnt_r)
      2'd0:    sq_op = item_r.std_east;
      2'd1:    sq_op = item_r.std_north;
      default: sq_op = item_r.std_up;
    endcase
    sq_prod = 32'(sq_op) * 32'(sq_op);
  end

  // A pair result is the last one when no enabled sensor follows it.
  always_comb begin
    last_flag = 1'b1;
    for (int i = 0; i < NS; i++) begin
      if ((SW'(i) > sen_r) && en_r[i]) begin
        last_flag = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    limit_nxt      = limit_r;
    window_nxt     = window_r;
    thr_nxt        = thr_r;
    en_nxt         = en_r;
    count_nxt      = count_r;
    newest_nxt     = newest_r;
    sstart_nxt     = sstart_r;
    found_nxt      = found_r;
    held_idx_nxt   = held_idx_r;
    held_valid_nxt = held_valid_r;
    held_time_nxt  = held_time_r;
    last_acc_nxt   = last_acc_r;
    sq_nxt         = sq_r;
    qcnt_nxt       = qcnt_r;
    sen_nxt        = sen_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    gap_nxt        = gap_r;
    pick_nxt       = pick_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = mem_addr(sen_r, cnt_cur[IW-1:0]);
    mem_raddr      = mem_addr(sen_r, mid_cur[IW-1:0]);

    if (cfg_we) begin
      unique case (cfg_index)
        glts_pkg::CFG_STD_LIMIT: limit_nxt  = cfg_wdata;
        glts_pkg::CFG_WINDOW:    window_nxt = cfg_wdata[31:0];
        glts_pkg::CFG_THROTTLE:  thr_nxt    = cfg_wdata[31:0];
        glts_pkg::CFG_ENABLE:    en_nxt     = cfg_wdata[NS-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        if (!item_r.mode) begin
          if (item_r.sensor_id >= 3'd1 && 32'(item_r.sensor_id) <= NS) begin
            sen_nxt   = SW'(item_r.sensor_id - 3'd1);
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          sq_nxt    = '0;
          qcnt_nxt  = 2'd0;
          state_nxt = S_SQ;
        end
      end

      S_LOAD: begin
        // Appends only when the table has room and time does not go back.
        if (32'(cnt_cur) < glts_pkg::FRAMES_PER_SENSOR &&
            (cnt_cur == '0 || t >= newest_r[sen_r])) begin
          mem_we             = 1'b1;
          count_nxt[sen_r]   = cnt_cur + CW'(1);
          newest_nxt[sen_r]  = t;
        end
        state_nxt = S_IDLE;
      end

      S_SQ: begin
        sq_nxt   = sq_r + glts_pkg::LIMIT_W'(sq_prod);
        qcnt_nxt = qcnt_r + 2'd1;
        if (qcnt_r == 2'd2) begin
          state_nxt = S_QCHK;
        end
      end

      S_QCHK: begin
        if (sq_r > limit_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{glts_pkg::ST_BAD_QUAL, 3'd0, 12'd0, '0, '0, 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_THR;
        end
      end

      S_THR: begin
        if (last_acc_r != '0 && (cmp.a_lt_b || cmp.diff < TB'(thr_r))) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{glts_pkg::ST_THROTTLE, 3'd0, 12'd0, '0, '0, 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          last_acc_nxt = t;
          sen_nxt      = '0;
          for (int i = 0; i < NS; i++) begin
            found_nxt[i] = '0;
          end
          state_nxt = S_SINIT;
        end
      end

      S_SINIT: begin
        if (!en_r[sen_r]) begin
          state_nxt = S_NEXT;
        end else if (cnt_cur == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{glts_pkg::ST_NO_MATCH, 3'd0, 12'd0, '0, '0, 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          lo_nxt    = (CW'(sstart_r[sen_r]) >= cnt_cur) ? cnt_cur - CW'(1)
                                                       : CW'(sstart_r[sen_r]);
          hi_nxt    = cnt_cur;
          state_nxt = S_BS_RD;
        end
      end

      S_BS_RD: begin
        if (lo_r < hi_r) begin
          mem_re    = 1'b1;
          mid_nxt   = mid_cur;
          state_nxt = S_BS_CMP;
        end else begin
          state_nxt = S_NEAR;
        end
      end

      S_BS_CMP: begin
        // Lower-bound step: stored time below the record moves lo up.
        if (cmp.b_lt_a) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_BS_RD;
      end

      S_NEAR: begin
        mem_re = 1'b1;
        if (lo_r >= cnt_cur) begin
          pick_nxt  = IW'(cnt_cur - CW'(1));
          mem_raddr = mem_addr(sen_r, IW'(cnt_cur - CW'(1)));
          state_nxt = S_ONE;
        end else if (lo_r == '0) begin
          pick_nxt  = '0;
          mem_raddr = mem_addr(sen_r, '0);
          state_nxt = S_ONE;
        end else begin
          mem_raddr = mem_addr(sen_r, IW'(lo_r - CW'(1)));
          state_nxt = S_PREV;
        end
      end

      S_ONE: begin
        gap_nxt   = cmp.diff;
        state_nxt = S_WIN;
      end

      S_PREV: begin
        gap_nxt   = cmp.diff;
        mem_re    = 1'b1;
        mem_raddr = mem_addr(sen_r, lo_r[IW-1:0]);
        state_nxt = S_CUR;
      end

      S_CUR: begin
        // A tie goes to the later frame.
        if (gap_r < cmp.diff) begin
          pick_nxt = IW'(lo_r - CW'(1));
        end else begin
          pick_nxt = lo_r[IW-1:0];
          gap_nxt  = cmp.diff;
        end
        state_nxt = S_WIN;
      end

      S_WIN: begin
        if (gap_r > TB'(window_r)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{glts_pkg::ST_NO_MATCH, 3'd0, 12'd0, '0, '0, 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          sstart_nxt[sen_r] = pick_r;
          found_nxt[sen_r]  = pick_r;
          state_nxt         = S_NEXT;
        end
      end

      S_NEXT: begin
        if (32'(sen_r) != NS - 1) begin
          sen_nxt   = sen_r + SW'(1);
          state_nxt = S_SINIT;
        end else if (!held_valid_r || en_r == '0) begin
          out_valid_nxt = 1'b1;
          if (!held_valid_r) begin
            out_nxt = '{glts_pkg::ST_FIRST, 3'd0, 12'd0, t, '0, 1'b1};
          end else begin
            out_nxt = '{glts_pkg::ST_PAIR, 3'd0, 12'd0, held_time_r, t, 1'b1};
          end
          held_idx_nxt   = found_r;
          held_time_nxt  = t;
          held_valid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          sen_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (en_r[sen_r]) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{glts_pkg::ST_PAIR, 3'(sen_r) + 3'd1,
                            12'(held_idx_r[sen_r]), held_time_r, t, last_flag};
        end
        if (32'(sen_r) == NS - 1) begin
          held_idx_nxt   = found_r;
          held_time_nxt  = t;
          held_valid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          sen_nxt = sen_r + SW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= glts_pkg::LIMIT_W'(250000);
      window_r     <= 32'd50000;
      thr_r        <= 32'd90000;
      en_r         <= '1;
      held_valid_r <= 1'b0;
      held_time_r  <= '0;
      last_acc_r   <= '0;
      sen_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        count_r[i]    <= '0;
        sstart_r[i]   <= '0;
        held_idx_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      window_r     <= window_nxt;
      thr_r        <= thr_nxt;
      en_r         <= en_nxt;
      held_valid_r <= held_valid_nxt;
      held_time_r  <= held_time_nxt;
      last_acc_r   <= last_acc_nxt;
      sen_r        <= sen_nxt;
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      sstart_r     <= sstart_nxt;
      held_idx_r   <= held_idx_nxt;
    end
    item_r   <= item_nxt;
    newest_r <= newest_nxt;
    found_r  <= found_nxt;
    sq_r     <= sq_nxt;
    qcnt_r   <= qcnt_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    gap_r    <= gap_nxt;
    pick_r   <= pick_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

[sv/glts_checker.sv]
// ----------------------------------------------------------------------------
// glts_checker : port-level checks of the timestamp synchroniser
// Watches the result stream and the command handshake over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glts_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire glts_pkg::out_item_t        out_item
);

  // An accepted transaction holds the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepted transaction");

  // Status-only results always close their transaction.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != glts_pkg::ST_PAIR |-> out_item.last)
    else $error("status-only result without last");

  // A final result may not be directly followed by another result.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result directly after last");

  // Non-pair results carry no sensor.
  a_no_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != glts_pkg::ST_PAIR |-> out_item.out_sensor == 3'd0)
    else $error("status-only result names a sensor");

endmodule

bind gnss_lidar_timestamp_sync glts_checker u_glts_checker (.*);

`default_nettype wire
